// ===== rtl/core/sfxd_pkg.sv =====
// Package: shared constants, types and codes for the serial frame deframer.
package sfxd_pkg;

  localparam int MAX_FRAME_DEF = 64;
  localparam int DATA_W        = 8;
  localparam int IDX_W         = 6;
  localparam int CNT_W         = 9;
  localparam int COUNT_SAT     = 256;
  localparam int STORE_AW_MAX  = 8;
  localparam int QUEUE_DEPTH   = 2;
  localparam int CFG_IDX_W     = 1;

  localparam logic [CNT_W-1:0]  LEN_POS_PLAIN  = 9'h003;
  localparam logic [CNT_W-1:0]  LEN_POS_UID    = 9'h005;
  localparam logic [DATA_W-1:0] START_BYTE_RST = 8'hFF;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_START_BYTE = 1'b0,
    REG_USE_UID    = 1'b1
  } cfg_reg_e;

  typedef enum logic {
    BK_IDLE,
    BK_SHOW
  } back_state_e;

  typedef struct packed {
    logic                    en;
    logic [STORE_AW_MAX-1:0] addr;
    logic [DATA_W-1:0]       data;
  } store_wr_t;

endpackage

// ===== rtl/core/sfxd_if.sv =====
// Interfaces: receive byte, frame byte and configuration write channels.
interface sfxd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface sfxd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic [5:0] byte_index;
  logic       frame_last;
  modport source (output valid, output frame_byte, output byte_index, output frame_last,
                  input ready);
  modport sink (input valid, input frame_byte, input byte_index, input frame_last,
                output ready);
endinterface

interface sfxd_cfg_if;
  logic       valid;
  logic       ready;
  logic [0:0] index;
  logic [7:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/sfxd_queue.sv =====
// Short frame descriptor queue between the front and back parts.
module sfxd_queue import sfxd_pkg::*; #(
  parameter int W = 7
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  logic [W-1:0] push_data_i,
  input  logic         pop_i,
  output logic         valid_o,
  output logic [W-1:0] data_o
);

  localparam int PtrW = $clog2(QUEUE_DEPTH);
  localparam int FillW = $clog2(QUEUE_DEPTH + 1);

  logic [W-1:0]     entry_q [QUEUE_DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [FillW-1:0] fill_q, fill_d;
  logic             do_push, do_pop;

  assign do_push = push_i && (fill_q != FillW'(QUEUE_DEPTH));
  assign do_pop  = pop_i && (fill_q != '0);
  assign valid_o = fill_q != '0;
  assign data_o  = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + PtrW'(1) : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + PtrW'(1) : rd_ptr_q;
    fill_d   = fill_q;
    if (do_push && !do_pop) begin
      fill_d = fill_q + FillW'(1);
    end else if (do_pop && !do_push) begin
      fill_d = fill_q - FillW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ===== rtl/core/sfxd_front.sv =====
// Front part: takes received bytes, tracks count, checksum and length, detects completion.
module sfxd_front import sfxd_pkg::*; #(
  parameter int MaxFrame = MAX_FRAME_DEF,
  parameter int LenW     = $clog2(MAX_FRAME_DEF + 1)
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  sfxd_in_if.sink         rx,
  sfxd_cfg_if.sink        cfg,
  input  logic            busy_i,
  output store_wr_t       store_wr_o,
  output logic            push_o,
  output logic [LenW-1:0] push_len_o
);

  logic [DATA_W-1:0] start_byte_q;
  logic              use_uid_q;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [DATA_W-1:0] xor_q, xor_d;
  logic [DATA_W-1:0] len_q, len_d;
  logic              ovf_q, ovf_d;

  logic              accept, is_start, fits, at_len, complete;
  logic [CNT_W-1:0]  cnt_base, len_pos;
  logic [DATA_W-1:0] xor_base, len_base;
  logic              ovf_base;

  assign rx.ready  = !busy_i;
  assign cfg.ready = 1'b1;
  assign accept    = rx.valid && rx.ready;

  always_comb begin
    is_start = rx.rx_byte == start_byte_q;
    len_pos  = use_uid_q ? LEN_POS_UID : LEN_POS_PLAIN;
    cnt_base = is_start ? '0 : cnt_q;
    xor_base = is_start ? '0 : xor_q;
    len_base = is_start ? '0 : len_q;
    ovf_base = is_start ? 1'b0 : ovf_q;

    fits  = cnt_base < CNT_W'(MaxFrame);
    ovf_d = ovf_base | !fits;
    cnt_d = (cnt_base < CNT_W'(COUNT_SAT)) ? cnt_base + CNT_W'(1) : cnt_base;
    xor_d = xor_base ^ rx.rx_byte;

    at_len   = !is_start && (cnt_d == len_pos);
    len_d    = at_len ? rx.rx_byte : len_base;
    complete = !is_start && !at_len && (cnt_d == {1'b0, len_base}) &&
               (xor_d == '0) && !ovf_d;

    store_wr_o.en   = accept && fits;
    store_wr_o.addr = cnt_base[STORE_AW_MAX-1:0];
    store_wr_o.data = rx.rx_byte;
    push_o          = accept && complete;
    push_len_o      = LenW'(cnt_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_byte_q <= START_BYTE_RST;
      use_uid_q    <= 1'b0;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.index)
        REG_START_BYTE: start_byte_q <= cfg.data;
        REG_USE_UID:    use_uid_q    <= cfg.data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      xor_q <= '0;
      len_q <= '0;
      ovf_q <= 1'b0;
    end else if (accept) begin
      cnt_q <= cnt_d;
      xor_q <= xor_d;
      len_q <= len_d;
      ovf_q <= ovf_d;
    end
  end

endmodule

// ===== rtl/core/sfxd_back.sv =====
// Back part: frame store and replay of a completed frame onto the output channel.
module sfxd_back import sfxd_pkg::*; #(
  parameter int MaxFrame = MAX_FRAME_DEF,
  parameter int LenW     = $clog2(MAX_FRAME_DEF + 1)
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  store_wr_t       store_wr_i,
  input  logic            desc_valid_i,
  input  logic [LenW-1:0] desc_len_i,
  output logic            desc_pop_o,
  output logic            busy_o,
  sfxd_out_if.source      frame
);

  localparam int AW = $clog2(MaxFrame);

  logic [DATA_W-1:0] store_q [MaxFrame];
  logic [DATA_W-1:0] rdata_q;

  back_state_e       state_q, state_d;
  logic [AW-1:0]     ptr_q, ptr_d;
  logic [LenW-1:0]   len_q, len_d;
  logic              out_valid_q, out_valid_d;
  logic [DATA_W-1:0] out_byte_q;
  logic [IDX_W-1:0]  out_idx_q;
  logic              out_last_q;

  logic              load, last, rd_en;
  logic [AW-1:0]     rd_addr;

  assign load = (state_q == BK_SHOW) && (!out_valid_q || frame.ready);
  assign last = (LenW'(ptr_q) + LenW'(1)) == len_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BK_IDLE: if (desc_valid_i) state_d = BK_SHOW;
      BK_SHOW: if (load && last) state_d = BK_IDLE;
      default: state_d = BK_IDLE;
    endcase
  end

  always_comb begin
    desc_pop_o = 1'b0;
    rd_en      = 1'b0;
    rd_addr    = ptr_q;
    ptr_d      = ptr_q;
    len_d      = len_q;
    unique case (state_q)
      BK_IDLE: begin
        if (desc_valid_i) begin
          desc_pop_o = 1'b1;
          rd_en      = 1'b1;
          rd_addr    = '0;
          ptr_d      = '0;
          len_d      = desc_len_i;
        end
      end
      BK_SHOW: begin
        if (load && !last) begin
          rd_en   = 1'b1;
          rd_addr = ptr_q + AW'(1);
          ptr_d   = ptr_q + AW'(1);
        end
      end
      default: ;
    endcase
    out_valid_d = load ? 1'b1 : (frame.ready ? 1'b0 : out_valid_q);
  end

  assign busy_o           = (state_q != BK_IDLE) || desc_valid_i;
  assign frame.valid      = out_valid_q;
  assign frame.frame_byte = out_byte_q;
  assign frame.byte_index = out_idx_q;
  assign frame.frame_last = out_last_q;

  always_ff @(posedge clk_i) begin
    if (store_wr_i.en) begin
      store_q[store_wr_i.addr[AW-1:0]] <= store_wr_i.data;
    end
    if (rd_en) begin
      rdata_q <= store_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      ptr_q       <= '0;
      len_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ptr_q       <= ptr_d;
      len_q       <= len_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_byte_q <= rdata_q;
      out_idx_q  <= IDX_W'(ptr_q);
      out_last_q <= last;
    end
  end

  a_ptr_in_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == BK_SHOW |-> LenW'(ptr_q) < len_q)
    else $error("replay pointer past frame length");

  a_len_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == BK_SHOW |-> len_q != '0)
    else $error("replaying an empty frame");

  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load && last |=> state_q == BK_IDLE)
    else $error("replay did not end after last byte");

endmodule

// ===== rtl/core/serial_frame_xor_deframer_core.sv =====
// Serial frame deframer top level: front, descriptor queue and back.
// Throughput: one received byte per cycle while no frame is being replayed.
// Replay: after the completing byte's transfer, the queue register, the store read register and
// the output register stand before the first frame byte, then one byte per cycle unless frame_o
// stalls; input stalls until replay ends. The store has separate write and read ports.
// Reset clears count, checksum, length, overflow and queue, sets config defaults; the store is not cleared.
module serial_frame_xor_deframer_core import sfxd_pkg::*; #(
  parameter int MaxFrame = MAX_FRAME_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  sfxd_in_if.sink    rx_i,
  sfxd_cfg_if.sink   cfg_i,
  sfxd_out_if.source frame_o
);

  localparam int LenW = $clog2(MaxFrame + 1);

  store_wr_t       store_wr;
  logic            push, desc_valid, desc_pop, busy;
  logic [LenW-1:0] push_len, desc_len;

  sfxd_front #(.MaxFrame(MaxFrame), .LenW(LenW)) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rx         (rx_i),
    .cfg        (cfg_i),
    .busy_i     (busy),
    .store_wr_o (store_wr),
    .push_o     (push),
    .push_len_o (push_len)
  );

  sfxd_queue #(.W(LenW)) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_len),
    .pop_i       (desc_pop),
    .valid_o     (desc_valid),
    .data_o      (desc_len)
  );

  sfxd_back #(.MaxFrame(MaxFrame), .LenW(LenW)) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .store_wr_i   (store_wr),
    .desc_valid_i (desc_valid),
    .desc_len_i   (desc_len),
    .desc_pop_o   (desc_pop),
    .busy_o       (busy),
    .frame        (frame_o)
  );

endmodule
